// File: rtl/combined_lcg_shuffle_rng_macros.svh
// Assertion macros used by the checker file of the generator.
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH

// Same-cycle implication, skipped while rst is high.
`define CLSR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, skipped while rst is high.
`define CLSR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/clsr_pkg.sv
// Constants, control word types and microprogram of the shuffled combined generator.
package clsr_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 32;

   localparam logic [30:0] MOD1           = 31'd2147483563;
   localparam logic [30:0] MOD2           = 31'd2147483399;
   localparam logic [15:0] MUL1           = 16'd40014;
   localparam logic [15:0] MUL2           = 16'd40692;
   // 2^31 is congruent to these values modulo MOD1 and MOD2.
   localparam logic [7:0]  FOLD1          = 8'd85;
   localparam logic [7:0]  FOLD2          = 8'd249;
   localparam logic [30:0] WRAP           = 31'd2147483562;
   localparam logic [30:0] NEAR_ONE_LIMIT = 31'd2147483305;
   localparam logic [30:0] SECOND_RESET   = 31'd123456789;
   // Negating the most negative seed gives 2^31, kept reduced modulo MOD2.
   localparam logic [30:0] NEG_MIN_SECOND = 31'd249;
   localparam int unsigned RECIP_SHIFT    = 56;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_FIRST,
      MUL_SECOND,
      MUL_RECIP,
      MUL_SLOT
   } mul_sel_type;

   typedef enum logic [1:0] {
      FIX_NONE,
      FIX_FIRST,
      FIX_SECOND
   } fix_dst_type;

   // Branch conditions: the jump target is taken when the condition is true.
   typedef enum logic [2:0] {
      SEQ_ALWAYS,
      SEQ_ON_DRAW,
      SEQ_ON_SEEDED,
      SEQ_ON_COUNT,
      SEQ_ON_BUSY
   } seq_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_R_MUL,
      ST_R_FOLD,
      ST_R_FIX,
      ST_S_MUL,
      ST_S_QUOT,
      ST_S_CMUL,
      ST_S_SLOT,
      ST_G1_MUL,
      ST_G1_FOLD,
      ST_G1_FIX,
      ST_G2_MUL,
      ST_G2_FOLD,
      ST_G2_FIX,
      ST_EMIT
   } step_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mod2;
      fix_dst_type fix_dst;
      logic        reseed_ld;
      logic        quot_ld;
      logic        slot_ld;
      logic        table_fill;
      logic        emit;
      seq_op_type  seq_op;
      step_type    next_step;
      step_type    jump_step;
   } ctrl_type;

   function automatic ctrl_type ucode(step_type s);
      ctrl_type cw;
      cw = '{mul_sel: MUL_NONE, mod2: 1'b0, fix_dst: FIX_NONE, reseed_ld: 1'b0,
             quot_ld: 1'b0, slot_ld: 1'b0, table_fill: 1'b0, emit: 1'b0,
             seq_op: SEQ_ALWAYS, next_step: ST_IDLE, jump_step: ST_IDLE};
      unique case (s)
         ST_IDLE: begin
            cw.seq_op    = SEQ_ON_DRAW;
            cw.next_step = ST_IDLE;
            cw.jump_step = ST_CHECK;
         end
         ST_CHECK: begin
            cw.reseed_ld = 1'b1;
            cw.seq_op    = SEQ_ON_SEEDED;
            cw.next_step = ST_R_MUL;
            cw.jump_step = ST_S_MUL;
         end
         ST_R_MUL: begin
            cw.mul_sel   = MUL_FIRST;
            cw.next_step = ST_R_FOLD;
         end
         ST_R_FOLD: begin
            cw.next_step = ST_R_FIX;
         end
         ST_R_FIX: begin
            cw.fix_dst    = FIX_FIRST;
            cw.table_fill = 1'b1;
            cw.seq_op     = SEQ_ON_COUNT;
            cw.next_step  = ST_S_MUL;
            cw.jump_step  = ST_R_MUL;
         end
         ST_S_MUL: begin
            cw.mul_sel   = MUL_RECIP;
            cw.next_step = ST_S_QUOT;
         end
         ST_S_QUOT: begin
            cw.quot_ld   = 1'b1;
            cw.next_step = ST_S_CMUL;
         end
         ST_S_CMUL: begin
            cw.mul_sel   = MUL_SLOT;
            cw.next_step = ST_S_SLOT;
         end
         ST_S_SLOT: begin
            cw.slot_ld   = 1'b1;
            cw.next_step = ST_G1_MUL;
         end
         ST_G1_MUL: begin
            cw.mul_sel   = MUL_FIRST;
            cw.next_step = ST_G1_FOLD;
         end
         ST_G1_FOLD: begin
            cw.next_step = ST_G1_FIX;
         end
         ST_G1_FIX: begin
            cw.fix_dst   = FIX_FIRST;
            cw.next_step = ST_G2_MUL;
         end
         ST_G2_MUL: begin
            cw.mul_sel   = MUL_SECOND;
            cw.next_step = ST_G2_FOLD;
         end
         ST_G2_FOLD: begin
            cw.mod2      = 1'b1;
            cw.next_step = ST_G2_FIX;
         end
         ST_G2_FIX: begin
            cw.mod2      = 1'b1;
            cw.fix_dst   = FIX_SECOND;
            cw.next_step = ST_EMIT;
         end
         ST_EMIT: begin
            cw.emit      = 1'b1;
            cw.seq_op    = SEQ_ON_BUSY;
            cw.next_step = ST_IDLE;
            cw.jump_step = ST_EMIT;
         end
         default: begin
            cw.next_step = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// File: rtl/combined_lcg_shuffle_rng.sv
// Combined two-generator multiplicative random source with a shuffle table, microcoded.
//
//   Channel   Direction   Payload (lowest bit first)
//   req_*     in          tdata: seed_value[31:0]; tuser: func (0 draw, 1 load seed)
//   rsp_*     out         tdata: random_value[30:0], zero; tuser: near_one
//
// A seed transfer gives no result. A draw is accepted only while idle and closes the input
// until the sequencer is idle again; a reseed first refills the table. The multiplier is
// shared: a generator step is a multiply, a fold and a correction step, and the slot pick
// is a multiply, a quotient load, a check multiply and a slot load. Reset is synchronous
// and resets the generator state; the table is empty until the first reseed. While rsp
// stalls, the result waits in its register and the next draw holds in EMIT, input closed.
module combined_lcg_shuffle_rng #(
   parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic signed [31:0] req_tdata,   // seed_value[31:0]
   input  logic        [0:0]  req_tuser,   // func[0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic        [31:0] rsp_tdata,   // random_value[30:0], zero fill [31]
   output logic        [0:0]  rsp_tuser    // near_one[0]
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 8);
   localparam int unsigned Q_W   = $clog2(TABLE_DEPTH + 1);
   // Width of one table slot's share of the output range.
   localparam longint unsigned SLOT_DIV = 64'd1 + 64'(clsr_pkg::WRAP) / 64'(TABLE_DEPTH);
   // Reciprocal of SLOT_DIV scaled by 2^RECIP_SHIFT; the estimate is low by at most one.
   localparam longint unsigned RECIP = (64'd1 << clsr_pkg::RECIP_SHIFT) / SLOT_DIV;
   localparam logic [CNT_W-1:0] CNT_START = CNT_W'(TABLE_DEPTH + 7);
   localparam logic [CNT_W-1:0] CNT_FILL  = CNT_W'(TABLE_DEPTH);

   // Sequencer.
   clsr_pkg::step_type pc_ff, pc_in;
   clsr_pkg::ctrl_type cw;

   // Generator state.
   logic [31:0] first_ff, first_in;
   logic [30:0] second_ff, second_in;
   logic [30:0] last_ff, last_in;

   // Datapath registers.
   logic [63:0]      prod_ff;
   logic [31:0]      fold_ff;
   logic [Q_W-1:0]   q_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [30:0]      rd_ff;

   // Shuffle table.
   logic [30:0]      table_mem [TABLE_DEPTH];
   logic             tbl_we;
   logic [IDX_W-1:0] tbl_addr;
   logic [30:0]      tbl_wd;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_value_ff;
   logic        rsp_near_ff;

   logic        req_xfer, draw_req, seed_req;
   logic        need_reseed, out_free, cnt_zero, take_jump;
   logic [31:0] reseed_v;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [7:0]  fold_c;
   logic [24:0] fold_hi;
   logic [31:0] fold_in;
   logic [30:0] fix_m, fix_val;
   logic [IDX_W-1:0] slot_in;
   logic [32:0] diff;
   logic [30:0] y_val;
   logic        fill_hit;

   assign req_tready = (pc_ff == clsr_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign draw_req   = req_xfer & ~req_tuser[0];
   assign seed_req   = req_xfer & req_tuser[0];

   // The first generator reseeds when its state is zero or negative.
   assign need_reseed = first_ff[31] | (first_ff == 32'd0);
   assign reseed_v    = (first_ff == 32'd0) ? 32'd1 : (32'd0 - first_ff);
   assign out_free    = ~rsp_valid_ff | rsp_tready;
   assign cnt_zero    = (cnt_ff == '0);
   assign fill_hit    = (cnt_ff < CNT_FILL);

   // Fetch the control word of the current step.
   always_comb begin
      cw = clsr_pkg::ucode(pc_ff);
   end

   // Next step: branch to the jump target when the step's condition holds.
   always_comb begin
      unique case (cw.seq_op)
         clsr_pkg::SEQ_ALWAYS:    take_jump = 1'b0;
         clsr_pkg::SEQ_ON_DRAW:   take_jump = draw_req;
         clsr_pkg::SEQ_ON_SEEDED: take_jump = ~need_reseed;
         clsr_pkg::SEQ_ON_COUNT:  take_jump = ~cnt_zero;
         clsr_pkg::SEQ_ON_BUSY:   take_jump = ~out_free;
         default:                 take_jump = 1'b0;
      endcase
      pc_in = take_jump ? cw.jump_step : cw.next_step;
   end

   // Shared multiplier: each generator or the slot estimate against its constant.
   always_comb begin
      unique case (cw.mul_sel)
         clsr_pkg::MUL_FIRST: begin
            mul_a = first_ff;
            mul_b = 32'(clsr_pkg::MUL1);
         end
         clsr_pkg::MUL_SECOND: begin
            mul_a = {1'b0, second_ff};
            mul_b = 32'(clsr_pkg::MUL2);
         end
         clsr_pkg::MUL_RECIP: begin
            mul_a = {1'b0, last_ff};
            mul_b = 32'(RECIP);
         end
         clsr_pkg::MUL_SLOT: begin
            mul_a = 32'(q_ff) + 32'd1;
            mul_b = 32'(SLOT_DIV);
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Modular reduction for a modulus 2^31 - c: fold the high part down, then one
   // conditional subtract brings the sum below the modulus.
   assign fold_c  = cw.mod2 ? clsr_pkg::FOLD2 : clsr_pkg::FOLD1;
   assign fold_hi = 25'(prod_ff[47:31]) * 25'(fold_c);
   assign fold_in = {7'd0, fold_hi} + {1'b0, prod_ff[30:0]};
   assign fix_m   = cw.mod2 ? clsr_pkg::MOD2 : clsr_pkg::MOD1;
   assign fix_val = (fold_ff >= {1'b0, fix_m}) ? 31'(fold_ff - {1'b0, fix_m})
                                               : fold_ff[30:0];

   // Correct the quotient estimate upward when the next boundary is reached.
   assign slot_in = ({33'd0, last_ff} >= prod_ff) ? IDX_W'(q_ff + Q_W'(1))
                                                  : IDX_W'(q_ff);

   // New output: table entry minus second generator, wrapped into the output range.
   assign diff  = {2'b00, rd_ff} - {2'b00, second_ff};
   assign y_val = (diff[32] | (diff == 33'd0)) ? 31'(diff + 33'(clsr_pkg::WRAP))
                                               : diff[30:0];

   // Table write port: fill during reseed, refill the chosen slot on a draw.
   always_comb begin
      tbl_we   = 1'b0;
      tbl_addr = cnt_ff[IDX_W-1:0];
      tbl_wd   = fix_val;
      if (cw.emit) begin
         tbl_we   = out_free;
         tbl_addr = slot_ff;
         tbl_wd   = first_ff[30:0];
      end else if (cw.table_fill) begin
         tbl_we = fill_hit;
      end
   end

   // Next values of the generator state and loop counter.
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      last_in   = last_ff;
      cnt_in    = cnt_ff;
      if (seed_req) begin
         first_in = unsigned'(req_tdata);
      end else if (cw.reseed_ld && need_reseed) begin
         first_in  = reseed_v;
         second_in = reseed_v[31] ? clsr_pkg::NEG_MIN_SECOND : reseed_v[30:0];
         cnt_in    = CNT_START;
      end else if (cw.fix_dst == clsr_pkg::FIX_FIRST) begin
         first_in = {1'b0, fix_val};
         if (cw.table_fill) begin
            if (cnt_zero) begin
               // The last value written to slot zero seeds the slot choice.
               last_in = fix_val;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
      end else if (cw.fix_dst == clsr_pkg::FIX_SECOND) begin
         second_in = fix_val;
      end else if (cw.emit && out_free) begin
         last_in = y_val;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cw.emit && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= clsr_pkg::ST_IDLE;
         first_ff     <= 32'd0;
         second_ff    <= clsr_pkg::SECOND_RESET;
         last_ff      <= 31'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      fold_ff <= fold_in;
      cnt_ff  <= cnt_in;
      if (cw.quot_ld) begin
         q_ff <= prod_ff[clsr_pkg::RECIP_SHIFT +: Q_W];
      end
      if (cw.slot_ld) begin
         slot_ff <= slot_in;
      end
      if (cw.emit && out_free) begin
         rsp_value_ff <= y_val;
         rsp_near_ff  <= (y_val > clsr_pkg::NEAR_ONE_LIMIT);
      end
   end

   // Shuffle table memory with a registered read at the chosen slot.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_addr] <= tbl_wd;
      end
      rd_ff <= table_mem[slot_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_near_ff;

endmodule

// File: rtl/clsr_checker.sv
// Port-level checker for the shuffled combined generator, bound to its top level.
`include "combined_lcg_shuffle_rng_macros.svh"

module clsr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic signed [31:0] req_tdata,
   input logic        [0:0]  req_tuser,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic        [31:0] rsp_tdata,
   input logic        [0:0]  rsp_tuser
);

   logic draw_xfer;
   logic seed_xfer;

   assign draw_xfer = req_tvalid & req_tready & ~req_tuser[0];
   assign seed_xfer = req_tvalid & req_tready & req_tuser[0];

   `CLSR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `CLSR_ASSERT_IMP(a_near_one, clock, reset, rsp_tvalid, rsp_tuser[0] == (rsp_tdata[30:0] > clsr_pkg::NEAR_ONE_LIMIT), "near_one flag does not match value")
   `CLSR_ASSERT_NXT(a_draw_busy, clock, reset, draw_xfer, !req_tready ##1 !req_tready, "draw did not occupy the sequencer")
   `CLSR_ASSERT_NXT(a_seed_quick, clock, reset, seed_xfer, req_tready, "seed transfer blocked the input")
   `CLSR_ASSERT_NXT(a_reset_state, clock, 1'b0, reset, !rsp_tvalid && req_tready, "reset did not clear the handshake state")

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);
